### hdl/i2c_master_transfer_sequencer_top_macros.svh
// Assertion macros for the I2C transfer sequencer.
// Used by the top level only; the bodies are empty when SYNTHESIS is set.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// check on every edge outside reset
`define IMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define IMTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMTS_ASSERT(lbl, prop, msg)
`define IMTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/imts_pkg.sv
// Shared types and constants of the I2C transfer sequencer.
// No dependencies; imported by every sequencer module except imts_ram.
`timescale 1ns / 1ps
package imts_pkg;

  localparam int MAX_MESSAGES = 4;
  localparam int MSG_BYTES    = 64;
  localparam int MSG_W        = $clog2(MAX_MESSAGES);
  localparam int POS_W        = $clog2(MSG_BYTES);
  localparam int LEN_W        = 7;
  localparam int CNT_W        = 3;
  localparam int WS_DEPTH     = MAX_MESSAGES * MSG_BYTES;
  localparam int WS_AW        = $clog2(WS_DEPTH);

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_DESC = 2'd0,
    OP_LOAD_BYTE = 2'd1,
    OP_START     = 2'd2,
    OP_EVENT     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STW   = 3'd1,
    ACT_STR   = 3'd2,
    ACT_SEND  = 3'd3,
    ACT_RACK  = 3'd4,
    ACT_RNACK = 3'd5,
    ACT_STOP  = 3'd6
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_READ  = 5'b00100,
    PH_WRITE = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    BK_LOOK = 2'b01,
    BK_EXEC = 2'b10
  } bk_state_t;

  typedef struct packed {
    op_t              opcode;
    logic [1:0]       msg_slot;
    logic [5:0]       byte_pos;
    logic [6:0]       dev_addr;
    logic             is_read;
    logic [6:0]       msg_length;
    logic [7:0]       data_byte;
    logic [2:0]       msg_total;
    logic             no_ack;
  } in_t;

  typedef struct packed {
    act_t             action;
    logic [7:0]       out_byte;
    logic             rx_valid;
    logic [1:0]       rx_msg;
    logic [5:0]       rx_pos;
    logic [7:0]       rx_byte;
    logic             done_res;
    logic             status;
  } res_t;

  // classified item as handed from front to back
  typedef struct packed {
    op_t              opcode;
    logic [MSG_W-1:0] slot;
    logic [POS_W-1:0] pos;
    logic [6:0]       addr;
    logic             rd;
    logic [LEN_W-1:0] len;
    logic [7:0]       dbyte;
    logic [CNT_W-1:0] total;
    logic             nack;
    logic             ok;
  } cmd_t;

  typedef struct packed {
    logic [6:0]       addr;
    logic             rd;
    logic [LEN_W-1:0] len;
  } desc_t;

endpackage

### hdl/imts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/imts_front.sv
// Front end: accepts input items, classifies and saturates them, queues them.
// Depends on imts_pkg.
`timescale 1ns / 1ps
module imts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  imts_pkg::in_t in_item,
  output logic          q_empty,
  input  logic          q_pop,
  output imts_pkg::cmd_t q_head
);
  import imts_pkg::*;

  cmd_t             q_r [FQ_DEPTH];
  logic [FQ_PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd;
  logic             slot_ok, pos_ok, push_ok, pop_ok;

  always_comb begin
    slot_ok = 32'(in_item.msg_slot) < MAX_MESSAGES;
    pos_ok  = 32'(in_item.byte_pos) < MSG_BYTES;
    cmd.opcode = in_item.opcode;
    cmd.slot   = MSG_W'(in_item.msg_slot);
    cmd.pos    = POS_W'(in_item.byte_pos);
    cmd.addr   = in_item.dev_addr;
    cmd.rd     = in_item.is_read;
    cmd.len    = (32'(in_item.msg_length) > MSG_BYTES) ? LEN_W'(MSG_BYTES)
                                                       : in_item.msg_length;
    cmd.dbyte  = in_item.data_byte;
    cmd.total  = (32'(in_item.msg_total) > MAX_MESSAGES) ? CNT_W'(MAX_MESSAGES)
                                                         : in_item.msg_total;
    cmd.nack   = in_item.no_ack;
    unique case (in_item.opcode)
      OP_LOAD_DESC: cmd.ok = slot_ok;
      OP_LOAD_BYTE: cmd.ok = slot_ok && pos_ok;
      OP_START:     cmd.ok = (in_item.msg_total != '0);
      OP_EVENT:     cmd.ok = 1'b1;
      default:      cmd.ok = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = q_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && !q_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wp_nxt = (32'(wp_r) == FQ_DEPTH - 1) ? '0 : FQ_PW'(wp_r + 1'b1);
    end
    if (pop_ok) begin
      rp_nxt = (32'(rp_r) == FQ_DEPTH - 1) ? '0 : FQ_PW'(rp_r + 1'b1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = FQ_CW'(cnt_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = FQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

### hdl/imts_back.sv
// Back end: transfer sequencer with descriptor table and write byte store.
// Depends on imts_pkg and imts_ram.
`timescale 1ns / 1ps
module imts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  output logic           q_pop,
  input  imts_pkg::cmd_t cmd,
  input  logic           res_full,
  output logic           res_push,
  output imts_pkg::res_t res
);
  import imts_pkg::*;

  bk_state_t        bk_r, bk_nxt;
  phase_t           phase_r, phase_nxt;
  logic [MSG_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] clen_r, clen_nxt;
  logic             crd_r, crd_nxt;
  desc_t            desc_r [MAX_MESSAGES];

  logic             exec, ready, last;
  logic             desc_we, ram_we;
  logic [7:0]       ram_rdata;
  logic             do_start, do_eom, do_stop, stop_err, wr_chk, rd_chk;
  logic [MSG_W-1:0] start_idx;
  logic [LEN_W-1:0] rd_pos;
  desc_t            sd;

  imts_ram #(
    .WIDTH(8),
    .DEPTH(WS_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr({cmd.slot, cmd.pos}),
    .wdata(cmd.dbyte),
    .raddr({cur_r, pos_r[POS_W-1:0]}),
    .rdata(ram_rdata)
  );

  assign exec     = (bk_r == BK_EXEC);
  assign q_pop    = exec;
  assign res_push = exec;
  assign ready    = (phase_r == PH_IDLE) || (phase_r == PH_STOP);
  assign last     = (CNT_W'({1'b0, cur_r}) + CNT_W'(1)) >= cnt_r;

  always_comb begin
    unique case (bk_r)
      BK_LOOK: bk_nxt = (!q_empty && !res_full) ? BK_EXEC : BK_LOOK;
      BK_EXEC: bk_nxt = BK_LOOK;
      default: bk_nxt = BK_LOOK;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    clen_nxt  = clen_r;
    crd_nxt   = crd_r;
    res       = '0;
    desc_we   = 1'b0;
    ram_we    = 1'b0;
    do_start  = 1'b0;
    do_eom    = 1'b0;
    do_stop   = 1'b0;
    stop_err  = 1'b0;
    wr_chk    = 1'b0;
    rd_chk    = 1'b0;
    rd_pos    = pos_r;
    start_idx = MSG_W'(cur_r + 1'b1);
    sd        = desc_r[start_idx];

    if (exec) begin
      unique case (cmd.opcode)
        OP_LOAD_DESC: desc_we = ready && cmd.ok;
        OP_LOAD_BYTE: ram_we  = ready && cmd.ok;
        OP_START: begin
          if (ready && cmd.ok) begin
            cnt_nxt   = cmd.total;
            cur_nxt   = '0;
            pos_nxt   = '0;
            do_start  = 1'b1;
            start_idx = '0;
          end
        end
        OP_EVENT: begin
          unique case (phase_r)
            PH_START: begin
              if (cmd.nack) begin
                do_stop  = 1'b1;
                stop_err = 1'b1;
              end else if (last && pos_r >= clen_r) begin
                do_stop = 1'b1;
              end else if (crd_r) begin
                phase_nxt = PH_READ;
                rd_chk    = 1'b1;
              end else begin
                phase_nxt = PH_WRITE;
                wr_chk    = 1'b1;
              end
            end
            PH_WRITE: begin
              if (cmd.nack) begin
                do_stop  = 1'b1;
                stop_err = 1'b1;
              end else begin
                wr_chk = 1'b1;
              end
            end
            PH_READ: begin
              // deliver the byte that just came in, then decide the next receive
              if (pos_r < clen_r) begin
                res.rx_valid = 1'b1;
                res.rx_msg   = 2'(cur_r);
                res.rx_pos   = 6'(pos_r);
                res.rx_byte  = cmd.dbyte;
                pos_nxt      = LEN_W'(pos_r + 1'b1);
                rd_pos       = LEN_W'(pos_r + 1'b1);
              end
              rd_chk = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (wr_chk) begin
      if (pos_r < clen_r) begin
        res.action   = ACT_SEND;
        res.out_byte = ram_rdata;
        pos_nxt      = LEN_W'(pos_r + 1'b1);
      end else begin
        do_eom = 1'b1;
      end
    end

    if (rd_chk) begin
      if (rd_pos < clen_r) begin
        res.action = (LEN_W'(rd_pos + 1'b1) == clen_r) ? ACT_RNACK : ACT_RACK;
      end else begin
        do_eom = 1'b1;
      end
    end

    // advance to the next message or finish
    if (do_eom) begin
      if (!last) begin
        cur_nxt  = MSG_W'(cur_r + 1'b1);
        pos_nxt  = '0;
        do_start = 1'b1;
      end else begin
        do_stop = 1'b1;
      end
    end

    if (do_stop) begin
      phase_nxt    = PH_STOP;
      res.action   = ACT_STOP;
      res.done_res = 1'b1;
      res.status   = stop_err;
    end

    if (do_start) begin
      sd           = desc_r[start_idx];
      phase_nxt    = PH_START;
      res.action   = sd.rd ? ACT_STR : ACT_STW;
      res.out_byte = {sd.addr, sd.rd};
      clen_nxt     = sd.len;
      crd_nxt      = sd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r    <= BK_LOOK;
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      clen_r  <= '0;
      crd_r   <= 1'b0;
    end else begin
      bk_r    <= bk_nxt;
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      clen_r  <= clen_nxt;
      crd_r   <= crd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_r[cmd.slot] <= '{addr: cmd.addr, rd: cmd.rd, len: cmd.len};
    end
  end

endmodule

### hdl/imts_outq.sv
// Result queue: holds finished results until the receiver pops them.
// Depends on imts_pkg.
`timescale 1ns / 1ps
module imts_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_push,
  output logic           res_full,
  input  imts_pkg::res_t res,
  output logic           out_empty,
  input  logic           out_pop,
  output imts_pkg::res_t out_item
);
  import imts_pkg::*;

  res_t             q_r [OQ_DEPTH];
  logic [OQ_PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign res_full  = (cnt_r == OQ_CW'(OQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_item  = q_r[rp_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) begin
      wp_nxt = (32'(wp_r) == OQ_DEPTH - 1) ? '0 : OQ_PW'(wp_r + 1'b1);
    end
    if (pop_ok) begin
      rp_nxt = (32'(rp_r) == OQ_DEPTH - 1) ? '0 : OQ_PW'(rp_r + 1'b1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = OQ_CW'(cnt_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = OQ_CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= res;
    end
  end

endmodule

### hdl/i2c_master_transfer_sequencer_top.sv
// I2C master transfer sequencer, top level. Depends on imts_pkg, imts_front,
// imts_back, imts_outq, imts_ram and the assertion macro header.
//
// Input channel (in_push / in_full / in_item): descriptor loads, write byte
// loads, start commands and shifter bus events. Every item gives exactly one
// result on the output channel (out_empty / out_pop / out_item), in order.
// The front queues up to two classified items; the back sequencer handles one
// item in its look state (which reads the write byte store, whose read data is
// registered) and then its exec state (which forms the shifter command), and
// takes no new item before it is through with the last. An accepted item
// passes the front queue, the look and exec states and the result queue.
// Results wait in a two-entry result queue; while the receiver does not pop,
// the back stops once that queue is full and the front fills, then in_full
// rises. Nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues and returns the transfer
// to idle; descriptors and write bytes must be loaded again before use.
`timescale 1ns / 1ps
`include "i2c_master_transfer_sequencer_top_macros.svh"
module i2c_master_transfer_sequencer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  imts_pkg::in_t  in_item,
  output logic           out_empty,
  input  logic           out_pop,
  output imts_pkg::res_t out_item
);
  import imts_pkg::*;

  logic front_empty, front_pop, outq_full, outq_push;
  cmd_t front_head;
  res_t back_res;

  imts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .q_empty(front_empty),
    .q_pop  (front_pop),
    .q_head (front_head)
  );

  imts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (front_empty),
    .q_pop   (front_pop),
    .cmd     (front_head),
    .res_full(outq_full),
    .res_push(outq_push),
    .res     (back_res)
  );

  imts_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (outq_push),
    .res_full (outq_full),
    .res      (back_res),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  `IMTS_ASSERT(a_push_room, outq_push |-> !outq_full, "result pushed into full queue")
  `IMTS_ASSERT(a_pop_data, front_pop |-> !front_empty, "back took item from empty queue")
  `IMTS_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> (out_empty && !in_full), "queues not clear after reset")

endmodule

### tb/sv/imts_scoreboard_pkg.sv
// Scoreboard class for the I2C transfer sequencer testbench.
// Depends on imts_pkg for the item, result, phase and descriptor types.
`timescale 1ns / 1ps
package imts_scoreboard_pkg;
  import imts_pkg::*;

  class sequencer_scoreboard;
    phase_t     phase = PH_IDLE;
    logic [1:0] cur_msg = '0;
    logic [6:0] byte_idx = '0;
    logic [2:0] msg_cnt = '0;
    desc_t      descs [MAX_MESSAGES];
    logic [7:0] wr_bytes [WS_DEPTH];
    bit         desc_set [MAX_MESSAGES];
    bit         byte_set [WS_DEPTH];
    res_t       expected_cmds [$];
    int         failures = 0;

    function bit busy();
      return !(phase == PH_IDLE || phase == PH_STOP);
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void open_message(inout res_t r);
      desc_t d = descs[cur_msg];
      phase = PH_START;
      r.action = d.rd ? ACT_STR : ACT_STW;
      r.out_byte = {d.addr, d.rd};
    endfunction

    function void close_transfer(inout res_t r, input logic err);
      phase = PH_STOP;
      r.action = ACT_STOP;
      r.done_res = 1'b1;
      r.status = err;
    endfunction

    function bit on_last();
      return int'(cur_msg) + 1 >= int'(msg_cnt);
    endfunction

    function void end_message(inout res_t r);
      if (!on_last()) begin
        cur_msg++;
        byte_idx = '0;
        open_message(r);
      end else begin
        close_transfer(r, 1'b0);
      end
    endfunction

    function void advance_read(inout res_t r);
      if (byte_idx < descs[cur_msg].len)
        r.action = (byte_idx + 1 == descs[cur_msg].len) ? ACT_RNACK : ACT_RACK;
      else
        end_message(r);
    endfunction

    function void next_write(inout res_t r, input logic nack);
      if (nack) begin
        close_transfer(r, 1'b1);
      end else if (byte_idx < descs[cur_msg].len) begin
        r.action = ACT_SEND;
        r.out_byte = wr_bytes[{cur_msg, byte_idx[5:0]}];
        byte_idx++;
      end else begin
        end_message(r);
      end
    endfunction

    // Returns 1 when the item changed the state or produced a command.
    function bit next_command(in_t it, output res_t r);
      bit rdy = !busy();
      bit took = 1'b0;
      r = '0;
      case (it.opcode)
        OP_LOAD_DESC: if (rdy) begin
          descs[it.msg_slot].addr = it.dev_addr;
          descs[it.msg_slot].rd = it.is_read;
          descs[it.msg_slot].len = (it.msg_length > MSG_BYTES) ? 7'(MSG_BYTES) : it.msg_length;
          desc_set[it.msg_slot] = 1'b1;
          took = 1'b1;
        end
        OP_LOAD_BYTE: if (rdy) begin
          wr_bytes[{it.msg_slot, it.byte_pos}] = it.data_byte;
          byte_set[{it.msg_slot, it.byte_pos}] = 1'b1;
          took = 1'b1;
        end
        OP_START: if (rdy && it.msg_total != 0) begin
          msg_cnt = (it.msg_total > MAX_MESSAGES) ? 3'(MAX_MESSAGES) : it.msg_total;
          cur_msg = '0;
          byte_idx = '0;
          open_message(r);
          took = 1'b1;
        end
        default: begin
          took = !rdy;
          case (phase)
            PH_START: begin
              if (it.no_ack)
                close_transfer(r, 1'b1);
              else if (on_last() && byte_idx >= descs[cur_msg].len)
                close_transfer(r, 1'b0);
              else if (descs[cur_msg].rd) begin
                phase = PH_READ;
                advance_read(r);
              end else begin
                phase = PH_WRITE;
                next_write(r, 1'b0);
              end
            end
            PH_WRITE: next_write(r, it.no_ack);
            PH_READ: begin
              // no_ack plays no part while receiving
              if (byte_idx < descs[cur_msg].len) begin
                r.rx_valid = 1'b1;
                r.rx_msg = cur_msg;
                r.rx_pos = byte_idx[5:0];
                r.rx_byte = it.data_byte;
                byte_idx++;
              end
              advance_read(r);
            end
            default: ;
          endcase
        end
      endcase
      return took;
    endfunction

    function bit note(in_t it);
      res_t r;
      bit took;
      took = next_command(it, r);
      expected_cmds.push_back(r);
      return took;
    endfunction

    function string describe(res_t r);
      return $sformatf("act=%0d byte=%02h rx=%b msg=%0d pos=%0d rxb=%02h done=%b st=%b",
                       r.action, r.out_byte, r.rx_valid, r.rx_msg, r.rx_pos, r.rx_byte,
                       r.done_res, r.status);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check(res_t got);
      res_t exp;
      if (expected_cmds.size() == 0) begin
        flag($sformatf("result with nothing expected: %s", describe(got)));
        return;
      end
      exp = expected_cmds.pop_front();
      if (got.action !== exp.action || got.out_byte !== exp.out_byte ||
          got.rx_valid !== exp.rx_valid || got.rx_msg !== exp.rx_msg ||
          got.rx_pos !== exp.rx_pos || got.rx_byte !== exp.rx_byte ||
          got.done_res !== exp.done_res || got.status !== exp.status)
        flag($sformatf("mismatch: expected %s, got %s", describe(exp), describe(got)));
    endfunction
  endclass

endpackage

### tb/sv/tb_i2c_master_transfer_sequencer_top.sv
// Testbench top for the I2C transfer sequencer: directed and random transfers.
// Depends on imts_pkg, imts_scoreboard_pkg and i2c_master_transfer_sequencer_top.
`timescale 1ns / 1ps
module tb_i2c_master_transfer_sequencer_top;
  import imts_pkg::*;
  import imts_scoreboard_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_t  in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  res_t out_item;

  sequencer_scoreboard sb = new;
  int send_burst = 0;
  int recv_burst = 0;
  int live_items = 0;
  int results = 0;
  int idle_cycles = 0;
  bit paused = 1'b0;

  i2c_master_transfer_sequencer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #1 clk = ~clk;

  // Mostly random gaps, with occasional runs of back-to-back items.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic in_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic logic [6:0] pick_len();
    int r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(0, 4));
    if (r < 90) return 7'($urandom_range(5, 16));
    if (r < 98) return 7'($urandom_range(17, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  // A start is safe only when every descriptor and write byte it reads is loaded.
  function automatic bit start_is_safe(int n);
    for (int m = 0; m < n; m++) begin
      if (!sb.desc_set[m]) return 1'b0;
      if (!sb.descs[m].rd)
        for (int p = 0; p < sb.descs[m].len; p++)
          if (!sb.byte_set[m * MSG_BYTES + p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send(input in_t it);
    int gap;
    @(negedge clk);
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    if (sb.note(it)) live_items++;
  endtask

  task automatic load_desc(input logic [1:0] slot, input logic [6:0] addr,
                           input logic rd, input logic [6:0] len);
    in_t it;
    it = rand_item();
    it.opcode = OP_LOAD_DESC;
    it.msg_slot = slot;
    it.dev_addr = addr;
    it.is_read = rd;
    it.msg_length = len;
    send(it);
  endtask

  task automatic load_byte(input logic [1:0] slot, input logic [5:0] pos,
                           input logic [7:0] val);
    in_t it;
    it = rand_item();
    it.opcode = OP_LOAD_BYTE;
    it.msg_slot = slot;
    it.byte_pos = pos;
    it.data_byte = val;
    send(it);
  endtask

  task automatic start_xfer(input logic [2:0] total);
    in_t it;
    it = rand_item();
    it.opcode = OP_START;
    it.msg_total = total;
    send(it);
  endtask

  task automatic bus_event(input logic nack, input logic [7:0] val);
    in_t it;
    it = rand_item();
    it.opcode = OP_EVENT;
    it.no_ack = nack;
    it.data_byte = val;
    send(it);
  endtask

  // Feed bus events until the transfer stops, with stray loads and starts mixed in.
  task automatic finish_transfer();
    in_t it;
    logic nack;
    while (sb.busy()) begin
      if ($urandom_range(0, 14) == 0) begin
        it = rand_item();
        it.opcode = op_t'($urandom_range(0, 2));
        send(it);
      end else begin
        nack = (sb.phase == PH_READ) ? 1'($urandom_range(0, 1))
                                     : ($urandom_range(0, 39) == 0);
        bus_event(nack, 8'($urandom));
      end
    end
  endtask

  task automatic run_transfer(input int n);
    int total;
    for (int m = 0; m < n; m++)
      if (!sb.desc_set[m] || $urandom_range(0, 9) < 7)
        load_desc(2'(m), 7'($urandom), 1'($urandom), pick_len());
    for (int m = 0; m < n; m++)
      if (!sb.descs[m].rd)
        for (int p = 0; p < sb.descs[m].len; p++)
          if (!sb.byte_set[m * MSG_BYTES + p] || $urandom_range(0, 3) == 0)
            load_byte(2'(m), 6'(p), 8'($urandom));
    total = (n == MAX_MESSAGES && $urandom_range(0, 1)) ? $urandom_range(4, 7) : n;
    start_xfer(3'(total));
    finish_transfer();
  endtask

  // Hold the input side until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    bus_event(1'b0, 8'h5A);
    start_xfer(3'd0);
    load_desc(2'd0, 7'h7F, 1'b0, 7'd2);
    load_byte(2'd0, 6'd0, 8'hFF);
    load_byte(2'd0, 6'd1, 8'h00);
    load_desc(2'd1, 7'h00, 1'b1, 7'd2);
    load_desc(2'd2, 7'h55, 1'b0, 7'd0);
    load_desc(2'd3, 7'h2A, 1'b1, 7'd127);
    start_xfer(3'd3);
    bus_event(1'b0, 8'h00);
    // busy: both get dropped
    load_desc(2'd0, 7'h11, 1'b1, 7'd1);
    start_xfer(3'd1);
    bus_event(1'b0, 8'hFF);
    bus_event(1'b0, 8'h00);
    bus_event(1'b0, 8'h3C);
    bus_event(1'b1, 8'hFF);
    bus_event(1'b1, 8'h00);
    bus_event(1'b0, 8'h81);
    load_byte(2'd3, 6'd63, 8'hA5);
    start_xfer(3'd1);
    bus_event(1'b1, 8'h42);
    bus_event(1'b0, 8'h24);
    drain();

    live_items = 0;
    while (live_items < 1150) begin
      if (!paused && live_items >= 575) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        run_transfer($urandom_range(1, MAX_MESSAGES));
      end else begin
        case ($urandom_range(0, 4))
          0: bus_event(1'($urandom), 8'($urandom));
          1: start_xfer(3'd0);
          2: load_desc(2'($urandom), 7'($urandom), 1'($urandom), pick_len());
          3: load_byte(2'($urandom), 6'($urandom), 8'($urandom));
          default: begin
            n = $urandom_range(1, MAX_MESSAGES);
            if (start_is_safe(n)) begin
              start_xfer(3'(n));
              finish_transfer();
            end
          end
        endcase
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = draw_gap(recv_burst);
      // one long hold-off so the block backs up into in_full
      if (results == HOLD_AT) gap = HOLD_LEN;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check(out_item);
      results++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
